FILE: rtl/cds_pkg.sv
`default_nettype none

package cds_pkg;

    localparam int FIRST_YEAR = 1900;
    localparam int LAST_YEAR  = 2100;

    localparam int OP_W     = 3;
    localparam int YEAR_W   = 12;
    localparam int MONTH_W  = 4;
    localparam int DAY_W    = 5;
    localparam int COUNT_W  = 18;
    localparam int ORDER_W  = 2;
    localparam int STATUS_W = 2;

    typedef enum logic [OP_W-1:0] {
        OP_SET  = 3'd0,
        OP_NEXT = 3'd1,
        OP_PREV = 3'd2,
        OP_ADD  = 3'd3,
        OP_CMP  = 3'd4,
        OP_DIFF = 3'd5
    } op_t;

    localparam logic [ORDER_W-1:0] ORDER_EARLIER = 2'd0;
    localparam logic [ORDER_W-1:0] ORDER_EQUAL   = 2'd1;
    localparam logic [ORDER_W-1:0] ORDER_LATER   = 2'd2;

    localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_INVALID = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_LIMIT   = 2'd2;

    // year first: packed compare orders dates field by field
    typedef struct packed {
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
    } date_t;

    localparam date_t FIRST_DATE = '{year: YEAR_W'(FIRST_YEAR), month: 4'd1, day: 5'd1};
    localparam date_t LAST_DATE  = '{year: YEAR_W'(LAST_YEAR), month: 4'd12, day: 5'd31};

    // century years matched against the constant list inside the year span
    function automatic logic is_leap(input logic [YEAR_W-1:0] y);
        logic div100;
        logic div400;
        int   k;
        div100 = 1'b0;
        div400 = 1'b0;
        for (k = FIRST_YEAR / 100; k <= LAST_YEAR / 100; k++)
        begin
            if (y == YEAR_W'(k * 100))
            begin
                div100 = 1'b1;
            end
        end
        for (k = FIRST_YEAR / 400; k <= LAST_YEAR / 400; k++)
        begin
            if (y == YEAR_W'(k * 400))
            begin
                div400 = 1'b1;
            end
        end
        return (y[1:0] == 2'b00) && (!div100 || div400);
    endfunction

    function automatic logic [DAY_W-1:0] days_in(input logic [YEAR_W-1:0] y,
                                                 input logic [MONTH_W-1:0] m);
        logic [DAY_W-1:0] n;
        if (m == 4'd2)
        begin
            n = is_leap(y) ? 5'd29 : 5'd28;
        end
        else if (m inside {4'd4, 4'd6, 4'd9, 4'd11})
        begin
            n = 5'd30;
        end
        else
        begin
            n = 5'd31;
        end
        return n;
    endfunction

    function automatic logic date_valid(input date_t dt);
        return (dt.year >= YEAR_W'(FIRST_YEAR)) && (dt.year <= YEAR_W'(LAST_YEAR))
            && (dt.month >= 4'd1) && (dt.month <= 4'd12)
            && (dt.day != 5'd0) && (dt.day <= days_in(dt.year, dt.month));
    endfunction

endpackage

`default_nettype wire

FILE: rtl/cds_step.sv
`default_nettype none

module cds_step (
    input  var cds_pkg::date_t cur,
    input  wire logic          backward,
    output cds_pkg::date_t     nxt,
    output logic               at_limit
);

    logic [cds_pkg::DAY_W-1:0]   dim;
    logic [cds_pkg::DAY_W-1:0]   prev_dim;
    logic [cds_pkg::MONTH_W-1:0] prev_month;

    always_comb
    begin
        prev_month = cur.month - 4'd1;
        dim        = cds_pkg::days_in(cur.year, cur.month);
        prev_dim   = cds_pkg::days_in(cur.year, prev_month);
        nxt        = cur;
        if (backward)
        begin
            at_limit = (cur == cds_pkg::FIRST_DATE);
            if (cur.day > 5'd1)
            begin
                nxt.day = cur.day - 5'd1;
            end
            else if (cur.month == 4'd1)
            begin
                nxt.year  = cur.year - 12'd1;
                nxt.month = 4'd12;
                nxt.day   = 5'd31;
            end
            else
            begin
                nxt.month = prev_month;
                nxt.day   = prev_dim;
            end
        end
        else
        begin
            at_limit = (cur == cds_pkg::LAST_DATE);
            if (cur.day < dim)
            begin
                nxt.day = cur.day + 5'd1;
            end
            else if (cur.month == 4'd12)
            begin
                nxt.year  = cur.year + 12'd1;
                nxt.month = 4'd1;
                nxt.day   = 5'd1;
            end
            else
            begin
                nxt.month = cur.month + 4'd1;
                nxt.day   = 5'd1;
            end
        end
    end

endmodule

`default_nettype wire

FILE: rtl/calendar_date_stepper.sv
// Calendar date stepper: keeps one Gregorian date between 1900-01-01 and
// 2100-12-31 and runs one operation per input transfer (set, next, previous,
// add days, compare, difference). Each input transfer gives exactly one
// result transfer carrying the stored date, order, distance and status.
// Both channels use valid/stall; a transfer happens when valid is high and
// stall is low. item_stall is high while an operation is in progress.
// An item goes from idle to the run state. Set, compare and unused codes go
// on to the finish state; next, previous and add step the date until the
// count is used up or a year limit stops it, and a difference steps until
// the walked date meets the stored date. Add and difference walk one day per
// cycle through the single day-step unit. The finish state loads the result;
// the next item is taken in the cycle after the result is loaded.
// The result sits in an output register: a new item is accepted while it
// waits. If the receiver stalls and a second result is done, the block
// holds it and keeps item_stall high until the output register frees.
// Reset sets the date to 1900-01-01 and drops any pending result.
`default_nettype none

module calendar_date_stepper (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                item_valid,
    output logic                                     item_stall,
    input  wire logic [cds_pkg::OP_W-1:0]            operation,
    input  wire logic [cds_pkg::YEAR_W-1:0]          given_year,
    input  wire logic [cds_pkg::MONTH_W-1:0]         given_month,
    input  wire logic [cds_pkg::DAY_W-1:0]           given_day,
    input  wire logic signed [cds_pkg::COUNT_W-1:0]  day_count,
    output logic                                     result_valid,
    input  wire logic                                result_stall,
    output logic [cds_pkg::YEAR_W-1:0]               year_out,
    output logic [cds_pkg::MONTH_W-1:0]              month_out,
    output logic [cds_pkg::DAY_W-1:0]                day_out,
    output logic [cds_pkg::ORDER_W-1:0]              order,
    output logic signed [cds_pkg::COUNT_W-1:0]       distance,
    output logic [cds_pkg::STATUS_W-1:0]             status
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_RUN  = 3'b010,
        ST_FIN  = 3'b100
    } state_t;

    state_t state_reg, state_next;

    cds_pkg::op_t   op_reg, op_next;
    cds_pkg::date_t given_reg, given_next;
    cds_pkg::date_t walk_reg, walk_next;
    cds_pkg::date_t cur_reg, cur_next;

    logic signed [cds_pkg::COUNT_W-1:0] cnt_reg, cnt_next;
    logic signed [cds_pkg::COUNT_W-1:0] dist_reg, dist_next;
    logic [cds_pkg::ORDER_W-1:0]        res_order_reg, res_order_next;
    logic [cds_pkg::STATUS_W-1:0]       res_status_reg, res_status_next;

    logic                               result_valid_reg, result_valid_next;
    cds_pkg::date_t                     out_date_reg, out_date_next;
    logic [cds_pkg::ORDER_W-1:0]        out_order_reg, out_order_next;
    logic signed [cds_pkg::COUNT_W-1:0] out_dist_reg, out_dist_next;
    logic [cds_pkg::STATUS_W-1:0]       out_status_reg, out_status_next;

    cds_pkg::date_t given_in;
    cds_pkg::date_t cmp_b;
    cds_pkg::date_t step_out;
    logic           step_back;
    logic           at_limit;
    logic           cur_lt;
    logic           cur_eq;
    logic           given_ok;
    logic           accept;
    logic           out_free;

    assign given_in = '{year: given_year, month: given_month, day: given_day};
    assign cmp_b    = (op_reg == cds_pkg::OP_CMP) ? given_reg : walk_reg;
    assign cur_lt   = (cur_reg < cmp_b);
    assign cur_eq   = (cur_reg == cmp_b);
    assign given_ok = cds_pkg::date_valid(given_reg);

    // difference walks toward the stored date; add walks by the sign of the count
    assign step_back = (op_reg == cds_pkg::OP_DIFF) ? cur_lt : cnt_reg[cds_pkg::COUNT_W-1];

    cds_step u_step (
        .cur      (walk_reg),
        .backward (step_back),
        .nxt      (step_out),
        .at_limit (at_limit)
    );

    assign item_stall = (state_reg != ST_IDLE);
    assign accept     = item_valid && !item_stall;
    assign out_free   = !result_valid_reg || !result_stall;

    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        given_next      = given_reg;
        walk_next       = walk_reg;
        cur_next        = cur_reg;
        cnt_next        = cnt_reg;
        dist_next       = dist_reg;
        res_order_next  = res_order_reg;
        res_status_next = res_status_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    op_next         = cds_pkg::op_t'(operation);
                    given_next      = given_in;
                    walk_next       = (operation == cds_pkg::OP_DIFF) ? given_in : cur_reg;
                    dist_next       = '0;
                    res_order_next  = cds_pkg::ORDER_EARLIER;
                    res_status_next = cds_pkg::STATUS_OK;
                    if (operation == cds_pkg::OP_NEXT)
                    begin
                        cnt_next = 18'sd1;
                    end
                    else if (operation == cds_pkg::OP_PREV)
                    begin
                        cnt_next = -18'sd1;
                    end
                    else if (operation == cds_pkg::OP_ADD)
                    begin
                        cnt_next = day_count;
                    end
                    else
                    begin
                        cnt_next = '0;
                    end
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                case (op_reg)
                    cds_pkg::OP_SET:
                    begin
                        if (given_ok)
                        begin
                            cur_next = given_reg;
                        end
                        else
                        begin
                            res_status_next = cds_pkg::STATUS_INVALID;
                        end
                        state_next = ST_FIN;
                    end
                    cds_pkg::OP_NEXT, cds_pkg::OP_PREV, cds_pkg::OP_ADD:
                    begin
                        if (cnt_reg == '0)
                        begin
                            cur_next   = walk_reg;
                            state_next = ST_FIN;
                        end
                        else if (at_limit)
                        begin
                            cur_next        = walk_reg;
                            res_status_next = cds_pkg::STATUS_LIMIT;
                            state_next      = ST_FIN;
                        end
                        else
                        begin
                            walk_next = step_out;
                            cnt_next  = step_back ? (cnt_reg + 18'sd1) : (cnt_reg - 18'sd1);
                        end
                    end
                    cds_pkg::OP_CMP:
                    begin
                        if (cur_eq)
                        begin
                            res_order_next = cds_pkg::ORDER_EQUAL;
                        end
                        else if (cur_lt)
                        begin
                            res_order_next = cds_pkg::ORDER_EARLIER;
                        end
                        else
                        begin
                            res_order_next = cds_pkg::ORDER_LATER;
                        end
                        state_next = ST_FIN;
                    end
                    cds_pkg::OP_DIFF:
                    begin
                        if (!given_ok)
                        begin
                            res_status_next = cds_pkg::STATUS_INVALID;
                            state_next      = ST_FIN;
                        end
                        else if (cur_eq)
                        begin
                            if (dist_reg == '0)
                            begin
                                res_order_next = cds_pkg::ORDER_EQUAL;
                            end
                            else if (dist_reg[cds_pkg::COUNT_W-1])
                            begin
                                res_order_next = cds_pkg::ORDER_EARLIER;
                            end
                            else
                            begin
                                res_order_next = cds_pkg::ORDER_LATER;
                            end
                            state_next = ST_FIN;
                        end
                        else
                        begin
                            walk_next = step_out;
                            dist_next = step_back ? (dist_reg - 18'sd1) : (dist_reg + 18'sd1);
                        end
                    end
                    default:
                    begin
                        state_next = ST_FIN;
                    end
                endcase
            end
            ST_FIN:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        result_valid_next = result_valid_reg;
        out_date_next     = out_date_reg;
        out_order_next    = out_order_reg;
        out_dist_next     = out_dist_reg;
        out_status_next   = out_status_reg;
        if ((state_reg == ST_FIN) && out_free)
        begin
            result_valid_next = 1'b1;
            out_date_next     = cur_reg;
            out_order_next    = res_order_reg;
            out_dist_next     = dist_reg;
            out_status_next   = res_status_reg;
        end
        else if (!result_stall)
        begin
            result_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            cur_reg          <= cds_pkg::FIRST_DATE;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            cur_reg          <= cur_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        given_reg      <= given_next;
        walk_reg       <= walk_next;
        cnt_reg        <= cnt_next;
        dist_reg       <= dist_next;
        res_order_reg  <= res_order_next;
        res_status_reg <= res_status_next;
        out_date_reg   <= out_date_next;
        out_order_reg  <= out_order_next;
        out_dist_reg   <= out_dist_next;
        out_status_reg <= out_status_next;
    end

    assign result_valid = result_valid_reg;
    assign year_out     = out_date_reg.year;
    assign month_out    = out_date_reg.month;
    assign day_out      = out_date_reg.day;
    assign order        = out_order_reg;
    assign distance     = out_dist_reg;
    assign status       = out_status_reg;

`ifndef ASSERT_OFF
    a_cur_date_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cds_pkg::date_valid(cur_reg))
        else $error("stored date left the valid range");

    a_dist_only_diff: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FIN && op_reg != cds_pkg::OP_DIFF) |-> (dist_reg == '0))
        else $error("nonzero distance on an operation other than difference");

    a_result_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid_reg) |-> $past(state_reg == ST_FIN))
        else $error("result raised without a finished operation");

    a_busy_no_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN) |=> (state_reg != ST_IDLE))
        else $error("operation skipped the result stage");
`endif

endmodule

`default_nettype wire

FILE: sim/tb_calendar_date_stepper.sv
module tb_calendar_date_stepper;
    timeunit 1ns;
    timeprecision 1ps;

    import cds_pkg::*;

    localparam logic [OP_W-1:0] OP_RESERVED_LO = 3'd6;
    localparam logic [OP_W-1:0] OP_RESERVED_HI = 3'd7;
    localparam int RUN_LIMIT_NS  = 20_000_000;
    localparam int SETTLE_CYCLES = 20;

    typedef struct {
        logic [OP_W-1:0]           op;
        logic [YEAR_W-1:0]         year;
        logic [MONTH_W-1:0]        month;
        logic [DAY_W-1:0]          day;
        logic signed [COUNT_W-1:0] count;
    } date_request_t;

    typedef struct packed {
        logic [YEAR_W-1:0]         year;
        logic [MONTH_W-1:0]        month;
        logic [DAY_W-1:0]          day;
        logic [ORDER_W-1:0]        order;
        logic signed [COUNT_W-1:0] distance;
        logic [STATUS_W-1:0]       status;
    } date_result_t;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      item_valid = 1'b0;
    logic                      item_stall;
    logic [OP_W-1:0]           operation = '0;
    logic [YEAR_W-1:0]         given_year = '0;
    logic [MONTH_W-1:0]        given_month = '0;
    logic [DAY_W-1:0]          given_day = '0;
    logic signed [COUNT_W-1:0] day_count = '0;
    logic                      result_valid;
    logic                      result_stall = 1'b0;
    logic [YEAR_W-1:0]         year_out;
    logic [MONTH_W-1:0]        month_out;
    logic [DAY_W-1:0]          day_out;
    logic [ORDER_W-1:0]        order;
    logic signed [COUNT_W-1:0] distance;
    logic [STATUS_W-1:0]       status;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int long_walks_left = 3;

    calendar_date_stepper dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .operation    (operation),
        .given_year   (given_year),
        .given_month  (given_month),
        .given_day    (given_day),
        .day_count    (day_count),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .year_out     (year_out),
        .month_out    (month_out),
        .day_out      (day_out),
        .order        (order),
        .distance     (distance),
        .status       (status)
    );

    function automatic bit leap_year(int y);
        return (y % 400 == 0) || ((y % 100 != 0) && (y % 4 == 0));
    endfunction

    function automatic int month_length(int y, int m);
        int len;
        case (m)
            2: len = leap_year(y) ? 29 : 28;
            4, 6, 9, 11: len = 30;
            default: len = 31;
        endcase
        return len;
    endfunction

    function automatic bit date_ok(date_t dt);
        if (dt.year < FIRST_YEAR || dt.year > LAST_YEAR)
            return 1'b0;
        if (dt.month < 1 || dt.month > 12)
            return 1'b0;
        return (dt.day >= 1) && (dt.day <= month_length(dt.year, dt.month));
    endfunction

    // days since a fixed epoch; only called on valid dates
    function automatic int day_number(date_t dt);
        int p;
        int n;
        int k;
        p = int'(dt.year) - 1;
        n = 365 * p + p / 4 - p / 100 + p / 400;
        for (k = 1; k < int'(dt.month); k++)
            n += month_length(dt.year, k);
        return n + int'(dt.day);
    endfunction

    function automatic date_t date_of_number(int n);
        date_t dt;
        int    y;
        int    m;
        int    rest;
        y = FIRST_YEAR;
        m = 1;
        while (y < LAST_YEAR && day_number('{year: YEAR_W'(y + 1), month: 4'd1, day: 5'd1}) <= n)
            y++;
        rest = n - day_number('{year: YEAR_W'(y), month: 4'd1, day: 5'd1});
        while (m < 12 && rest >= month_length(y, m))
        begin
            rest -= month_length(y, m);
            m++;
        end
        dt.year = YEAR_W'(y);
        dt.month = MONTH_W'(m);
        dt.day = DAY_W'(rest + 1);
        return dt;
    endfunction

    class date_tracker;
        date_t        held_date;
        date_result_t pending_dates[$];
        int           mismatches;
        int           checked;
        int           refused;
        int           limited;
        int           op_seen[8];

        function new();
            held_date = FIRST_DATE;
        endfunction

        function void note_request(date_request_t r);
            date_result_t want;
            date_t        given;
            int           target;
            int           gap;
            want = '0;
            given.year = r.year;
            given.month = r.month;
            given.day = r.day;
            op_seen[r.op]++;
            case (r.op)
                OP_SET:
                begin
                    if (date_ok(given))
                        held_date = given;
                    else
                        want.status = STATUS_INVALID;
                end
                OP_NEXT, OP_PREV, OP_ADD:
                begin
                    if (r.op == OP_NEXT)
                        target = day_number(held_date) + 1;
                    else if (r.op == OP_PREV)
                        target = day_number(held_date) - 1;
                    else
                        target = day_number(held_date) + int'(r.count);
                    if (target < day_number(FIRST_DATE))
                    begin
                        target = day_number(FIRST_DATE);
                        want.status = STATUS_LIMIT;
                    end
                    else if (target > day_number(LAST_DATE))
                    begin
                        target = day_number(LAST_DATE);
                        want.status = STATUS_LIMIT;
                    end
                    held_date = date_of_number(target);
                end
                OP_CMP:
                begin
                    if (held_date == given)
                        want.order = ORDER_EQUAL;
                    else
                        want.order = (held_date < given) ? ORDER_EARLIER : ORDER_LATER;
                end
                OP_DIFF:
                begin
                    if (date_ok(given))
                    begin
                        gap = day_number(held_date) - day_number(given);
                        want.distance = COUNT_W'(gap);
                        if (gap < 0)
                            want.order = ORDER_EARLIER;
                        else if (gap == 0)
                            want.order = ORDER_EQUAL;
                        else
                            want.order = ORDER_LATER;
                    end
                    else
                        want.status = STATUS_INVALID;
                end
                default: ;
            endcase
            if (want.status == STATUS_INVALID)
                refused++;
            if (want.status == STATUS_LIMIT)
                limited++;
            want.year = held_date.year;
            want.month = held_date.month;
            want.day = held_date.day;
            pending_dates.push_back(want);
        endfunction

        function void check_result(date_result_t got);
            date_result_t want;
            if (pending_dates.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result transfer: %0d-%0d-%0d status %0d",
                             got.year, got.month, got.day, got.status);
                return;
            end
            want = pending_dates.pop_front();
            checked++;
            if (got.year !== want.year || got.month !== want.month
                || got.day !== want.day || got.order !== want.order
                || got.distance !== want.distance || got.status !== want.status)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("mismatch on result %0d: expected %0d-%0d-%0d order %0d dist %0d st %0d",
                             checked, want.year, want.month, want.day, want.order,
                             $signed(want.distance), want.status);
                    $display("    got %0d-%0d-%0d order %0d dist %0d st %0d",
                             got.year, got.month, got.day, got.order,
                             $signed(got.distance), got.status);
                end
            end
        endfunction
    endclass

    date_tracker tracker;

    initial
    begin
        forever #2 clk = ~clk;
    end

    initial
    begin
        #RUN_LIMIT_NS;
        $display("timeout with %0d results outstanding", tracker.pending_dates.size());
        $display("FAIL");
        $finish;
    end

    always @(negedge clk)
        result_stall <= ($urandom_range(99) < recv_stall_pct);

    always @(posedge clk)
    begin
        date_result_t seen;
        if (rst_n && result_valid && !result_stall)
        begin
            seen.year = year_out;
            seen.month = month_out;
            seen.day = day_out;
            seen.order = order;
            seen.distance = distance;
            seen.status = status;
            tracker.check_result(seen);
        end
    end

    // called at a falling edge, returns at the falling edge after the transfer
    task automatic send_request(date_request_t r);
        if ($urandom_range(99) < send_idle_pct)
        begin
            item_valid <= 1'b0;
            @(negedge clk);
            while ($urandom_range(99) < send_idle_pct)
                @(negedge clk);
        end
        item_valid <= 1'b1;
        operation <= r.op;
        given_year <= r.year;
        given_month <= r.month;
        given_day <= r.day;
        day_count <= r.count;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        tracker.note_request(r);
        @(negedge clk);
    endtask

    task automatic send_directed(logic [OP_W-1:0] op, int y, int m, int d, int n);
        date_request_t r;
        r.op = op;
        r.year = YEAR_W'(y);
        r.month = MONTH_W'(m);
        r.day = DAY_W'(d);
        r.count = COUNT_W'(n);
        send_request(r);
    endtask

    task automatic wait_drained();
        item_valid <= 1'b0;
        do
            @(negedge clk);
        while (tracker.pending_dates.size() != 0);
    endtask

    // mostly short walks around the held date so add and difference stay cheap
    function automatic date_request_t random_request();
        date_request_t r;
        date_t         pick_date;
        int            pick;
        int            first_num;
        int            last_num;
        int            n;
        int            y;
        first_num = day_number(FIRST_DATE);
        last_num = day_number(LAST_DATE);
        r.op = OP_NEXT;
        r.year = YEAR_W'($urandom);
        r.month = MONTH_W'($urandom);
        r.day = DAY_W'($urandom);
        r.count = COUNT_W'($urandom);
        pick = $urandom_range(99);
        if (pick < 18)
        begin
            r.op = OP_SET;
            if ($urandom_range(9) < 2)
                n = $urandom_range(1) ? last_num - int'($urandom_range(6))
                                      : first_num + int'($urandom_range(6));
            else
                n = $urandom_range(last_num, first_num);
            pick_date = date_of_number(n);
            r.year = pick_date.year;
            r.month = pick_date.month;
            r.day = pick_date.day;
        end
        else if (pick < 25)
        begin
            r.op = OP_SET;
            if ($urandom_range(1))
            begin
                y = FIRST_YEAR + int'($urandom_range(LAST_YEAR - FIRST_YEAR));
                if (leap_year(y))
                    y++;
                r.year = YEAR_W'(y);
                r.month = 4'd2;
                r.day = 5'd29;
            end
        end
        else if (pick < 37)
            r.op = OP_NEXT;
        else if (pick < 49)
            r.op = OP_PREV;
        else if (pick < 67)
        begin
            r.op = OP_ADD;
            if ($urandom_range(19) == 0)
                r.count = COUNT_W'(int'($urandom_range(6000)) - 3000);
            else
                r.count = COUNT_W'(int'($urandom_range(800)) - 400);
        end
        else if (pick < 77)
        begin
            r.op = OP_CMP;
            if ($urandom_range(1))
            begin
                r.year = tracker.held_date.year;
                r.month = $urandom_range(1) ? tracker.held_date.month
                                            : MONTH_W'($urandom_range(12, 1));
                r.day = DAY_W'($urandom_range(31));
            end
        end
        else if (pick < 92)
        begin
            r.op = OP_DIFF;
            n = day_number(tracker.held_date) + int'($urandom_range(1000)) - 500;
            if (n < first_num)
                n = first_num;
            if (n > last_num)
                n = last_num;
            pick_date = date_of_number(n);
            r.year = pick_date.year;
            r.month = pick_date.month;
            r.day = pick_date.day;
        end
        else if (pick < 96)
        begin
            r.op = OP_DIFF;
            r.year = $urandom_range(1) ? YEAR_W'($urandom_range(FIRST_YEAR - 1))
                                       : YEAR_W'($urandom_range(4095, LAST_YEAR + 1));
        end
        else if (pick < 98)
            r.op = $urandom_range(1) ? OP_RESERVED_LO : OP_RESERVED_HI;
        else if (long_walks_left > 0)
        begin
            long_walks_left--;
            if ($urandom_range(1))
            begin
                r.op = OP_ADD;
                r.count = $urandom_range(1) ? COUNT_W'($urandom_range(131071, 60000))
                                            : COUNT_W'(-int'($urandom_range(131072, 60000)));
            end
            else
            begin
                r.op = OP_DIFF;
                pick_date = date_of_number($urandom_range(last_num, first_num));
                r.year = pick_date.year;
                r.month = pick_date.month;
                r.day = pick_date.day;
            end
        end
        return r;
    endfunction

    task automatic run_random(int count);
        repeat (count)
            send_request(random_request());
    endtask

    initial
    begin
        tracker = new();
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        send_idle_pct = 24;
        recv_stall_pct = 82;
        send_directed(OP_PREV, 0, 0, 0, 0);
        send_directed(OP_SET, 1900, 2, 29, 0);
        send_directed(OP_SET, 2000, 2, 29, 0);
        send_directed(OP_NEXT, 0, 0, 0, 0);
        send_directed(OP_PREV, 0, 0, 0, 0);
        send_directed(OP_SET, 2100, 2, 29, 0);
        send_directed(OP_SET, 1899, 12, 31, 0);
        send_directed(OP_SET, 4095, 15, 31, -1);
        send_directed(OP_SET, 0, 0, 0, 0);
        send_directed(OP_SET, 2023, 4, 31, 0);
        send_directed(OP_SET, 2023, 13, 1, 0);
        send_directed(OP_SET, 2100, 12, 31, 0);
        send_directed(OP_NEXT, 0, 0, 0, 0);
        send_directed(OP_ADD, 0, 0, 0, 0);
        send_directed(OP_CMP, 2100, 12, 31, 0);
        send_directed(OP_CMP, 4095, 15, 31, 0);
        send_directed(OP_CMP, 0, 0, 0, 0);
        send_directed(OP_DIFF, 2100, 2, 29, 0);
        send_directed(OP_DIFF, 1900, 1, 1, 0);
        send_directed(OP_ADD, 0, 0, 0, -131072);
        send_directed(OP_DIFF, 2100, 12, 31, 0);
        send_directed(OP_DIFF, 1900, 1, 1, 0);
        send_directed(OP_ADD, 0, 0, 0, 131071);
        send_directed(OP_RESERVED_LO, 4095, 15, 31, -1);
        send_directed(OP_RESERVED_HI, 0, 0, 0, 0);
        run_random(25);
        wait_drained();

        send_idle_pct = 82;
        recv_stall_pct = 24;
        run_random(25);
        wait_drained();

        send_idle_pct = 0;
        recv_stall_pct = 0;
        run_random(25);
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("%0d results checked: %0d set, %0d next, %0d prev, %0d add, %0d compare",
                 tracker.checked, tracker.op_seen[OP_SET], tracker.op_seen[OP_NEXT],
                 tracker.op_seen[OP_PREV], tracker.op_seen[OP_ADD], tracker.op_seen[OP_CMP]);
        $display("%0d difference, %0d reserved code, %0d refused dates, %0d year-limit stops",
                 tracker.op_seen[OP_DIFF],
                 tracker.op_seen[OP_RESERVED_LO] + tracker.op_seen[OP_RESERVED_HI],
                 tracker.refused, tracker.limited);
        if (tracker.mismatches == 0 && tracker.pending_dates.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

FILE: sim.f
rtl/cds_pkg.sv
rtl/cds_step.sv
rtl/calendar_date_stepper.sv
sim/tb_calendar_date_stepper.sv
